FILE: rtl/bcfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcfs_pkg
// Shared constants, types and the fade arithmetic for the bitmap clip/fade
// pixel stream.
// ----------------------------------------------------------------------------
package bcfs_pkg;

   localparam int COORD_BITS    = 11;
   localparam int DIM_BITS      = 11;
   localparam int CNT_BITS      = 10;
   localparam int OPA_BITS      = 4;
   localparam int PIXEL_BITS    = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
   localparam int POS_BITS      = CSR_DATA_BITS + 1;

   localparam logic [DIM_BITS-1:0] MAX_IMAGE_DIM   = DIM_BITS'(1024);
   localparam logic [DIM_BITS-1:0] SCREEN_DIM_RST  = DIM_BITS'(240);
   localparam logic [OPA_BITS-1:0] FADE_LEVELS     = OPA_BITS'(10);

   // divide by 10 as (x * 205) >> 11, exact for x < 1024
   localparam logic [7:0] FADE_RECIP = 8'd205;
   localparam int         FADE_SHIFT = 11;

   localparam logic [5:0] RB_MAX = 6'd31;
   localparam logic [5:0] G_MAX  = 6'd63;

   typedef logic [PIXEL_BITS-1:0] pixel_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_X       = 3'd0,
      CSR_IMAGE_Y       = 3'd1,
      CSR_IMAGE_WIDTH   = 3'd2,
      CSR_IMAGE_HEIGHT  = 3'd3,
      CSR_SCREEN_WIDTH  = 3'd4,
      CSR_SCREEN_HEIGHT = 3'd5,
      CSR_OPACITY       = 3'd6
   } csr_index_type;

   function automatic logic [5:0] fade_chan(input logic [5:0] value,
                                            input logic [5:0] max_value,
                                            input logic [OPA_BITS-1:0] opa);
      logic [5:0]  diff;
      logic [9:0]  prod;
      logic [17:0] scaled;
      logic [5:0]  quot;
      diff   = max_value - value;
      prod   = 10'(diff * opa);
      scaled = 18'(prod * FADE_RECIP);
      quot   = scaled[FADE_SHIFT +: 6];
      return max_value - quot;
   endfunction

   function automatic pixel_type fade_pixel(input pixel_type pix,
                                            input logic [OPA_BITS-1:0] opa);
      logic [5:0] r;
      logic [5:0] g;
      logic [5:0] b;
      r = fade_chan({1'b0, pix[15:11]}, RB_MAX, opa);
      g = fade_chan(pix[10:5], G_MAX, opa);
      b = fade_chan({1'b0, pix[4:0]}, RB_MAX, opa);
      return {r[4:0], g, b[4:0]};
   endfunction

endpackage

FILE: rtl/bitmap_clip_fade_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_clip_fade_stream
// Streams RGB565 source pixels in raster order, flags each one as on or off
// screen, marks the last pixel of the image and fades colour toward white.
//
// Usage:
//   req_*  : source pixels, one transfer per pixel, raster order.
//   rsp_*  : one result per pixel: faded colour, visible flag, image_done.
//   csr_*  : register writes (index 0..6), always ready; write only while idle.
// Path: a req transfer passes the input register, then the result register,
//   before rsp_valid. Throughput: one pixel per cycle; both stages advance
//   together whenever the result register is empty or being taken.
// Stall: while rsp_stall holds a valid result the whole pipe freezes and
//   req_stall is raised; nothing is dropped or repeated.
// Reset: clears both stages, the column/row counters and loads register
//   defaults (screens 240x240, opacity 10, image origin and size 0).
// Position counters advance at req transfer and wrap after the last pixel.
// ----------------------------------------------------------------------------
module bitmap_clip_fade_stream (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  bcfs_pkg::pixel_type                req_source_pixel,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output bcfs_pkg::pixel_type                rsp_pixel_color,
   output logic                               rsp_visible,
   output logic                               rsp_image_done,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bcfs_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bcfs_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import bcfs_pkg::*;

   // configuration
   logic signed [COORD_BITS-1:0] image_x_ff;
   logic signed [COORD_BITS-1:0] image_y_ff;
   logic [DIM_BITS-1:0]          image_width_ff;
   logic [DIM_BITS-1:0]          image_height_ff;
   logic [DIM_BITS-1:0]          screen_width_ff;
   logic [DIM_BITS-1:0]          screen_height_ff;
   logic [OPA_BITS-1:0]          opacity_ff;

   logic [CNT_BITS-1:0] col_ff;
   logic [CNT_BITS-1:0] col_in;
   logic [CNT_BITS-1:0] row_ff;
   logic [CNT_BITS-1:0] row_in;

   logic      s1_valid_ff;
   pixel_type s1_pixel_ff;
   logic      s1_visible_ff;
   logic      s1_done_ff;

   logic      rsp_valid_ff;
   pixel_type rsp_pixel_ff;
   logic      rsp_visible_ff;
   logic      rsp_done_ff;

   logic                       advance;
   logic                       req_xfer;
   logic [DIM_BITS-1:0]        width_lim;
   logic [DIM_BITS-1:0]        height_lim;
   logic [DIM_BITS-1:0]        col_next;
   logic [DIM_BITS-1:0]        row_next;
   logic                       last_col;
   logic                       last_row;
   logic                       done_c;
   logic signed [POS_BITS-1:0] pos_x;
   logic signed [POS_BITS-1:0] pos_y;
   logic signed [POS_BITS-1:0] scr_w;
   logic signed [POS_BITS-1:0] scr_h;
   logic                       visible_c;
   pixel_type                  color_c;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_x_ff       <= '0;
         image_y_ff       <= '0;
         image_width_ff   <= '0;
         image_height_ff  <= '0;
         screen_width_ff  <= SCREEN_DIM_RST;
         screen_height_ff <= SCREEN_DIM_RST;
         opacity_ff       <= FADE_LEVELS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_X:       image_x_ff       <= csr_data[COORD_BITS-1:0];
            CSR_IMAGE_Y:       image_y_ff       <= csr_data[COORD_BITS-1:0];
            CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data[DIM_BITS-1:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data[DIM_BITS-1:0];
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[DIM_BITS-1:0];
            CSR_OPACITY:       opacity_ff       <= csr_data[OPA_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;
   assign req_xfer  = req_valid && !req_stall;

   // position and clipping
   always_comb begin
      width_lim  = (image_width_ff  > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : image_width_ff;
      height_lim = (image_height_ff > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : image_height_ff;
      col_next   = DIM_BITS'(col_ff) + DIM_BITS'(1);
      row_next   = DIM_BITS'(row_ff) + DIM_BITS'(1);
      last_col   = col_next >= width_lim;
      last_row   = row_next >= height_lim;
      done_c     = last_col && last_row;

      pos_x = POS_BITS'(image_x_ff) + signed'(POS_BITS'(col_ff));
      pos_y = POS_BITS'(image_y_ff) + signed'(POS_BITS'(row_ff));
      scr_w = signed'(POS_BITS'(screen_width_ff));
      scr_h = signed'(POS_BITS'(screen_height_ff));
      visible_c = (pos_x >= 0) && (pos_x < scr_w) && (pos_y >= 0) && (pos_y < scr_h);

      if (done_c) begin
         col_in = '0;
         row_in = '0;
      end else if (last_col) begin
         col_in = '0;
         row_in = row_next[CNT_BITS-1:0];
      end else begin
         col_in = col_next[CNT_BITS-1:0];
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_xfer) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_pixel_ff   <= req_source_pixel;
         s1_visible_ff <= visible_c;
         s1_done_ff    <= done_c;
      end
   end

   // fade
   assign color_c = (opacity_ff >= FADE_LEVELS) ? s1_pixel_ff
                                                : fade_pixel(s1_pixel_ff, opacity_ff);

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_pixel_ff   <= color_c;
         rsp_visible_ff <= s1_visible_ff;
         rsp_done_ff    <= s1_done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = rsp_pixel_ff;
   assign rsp_visible     = rsp_visible_ff;
   assign rsp_image_done  = rsp_done_ff;

   // checks
   a_done_clears_counters: assert property (@(posedge clock) disable iff (reset)
      req_xfer && done_c |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters not cleared after last pixel");

   a_counters_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !req_xfer |=> $stable(col_ff) && $stable(row_ff))
      else $error("position counters moved without a transfer");

   a_s1_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_pixel_ff))
      else $error("input stage lost a pixel during stall");

   a_opaque_passthrough: assert property (@(posedge clock) disable iff (reset)
      advance && s1_valid_ff && (opacity_ff >= FADE_LEVELS)
      |=> rsp_pixel_color == $past(s1_pixel_ff))
      else $error("opaque pixel altered");

endmodule
